@@ rtl/kvt_pkg.sv @@
// Shared types and codes for the key-value table.
package kvt_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_REMOVE = 2'd2
  } kvt_cmd_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_DUP  = 2'd1,
    ST_MISS = 2'd2,
    ST_FULL = 2'd3
  } kvt_status_t;

  localparam int CMD_W    = 2;
  localparam int KEY_W    = 32;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int HELD_W   = 5;

  // Broadcast strobes from the controller to every cell.
  typedef struct packed {
    logic append;  // write the query pair into the cell at index == count
    logic shift;   // cells at or above the hit take their upper neighbor's pair
  } kvt_cell_ctl_t;

endpackage

@@ rtl/kvt_if.sv @@
// Valid/ready channel interfaces for request and response words.
interface kvt_in_if;
  logic                         valid;
  logic                         ready;
  logic [kvt_pkg::CMD_W-1:0]    cmd;
  logic [kvt_pkg::KEY_W-1:0]    key;
  logic [kvt_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output cmd, output key, output value, input ready);
  modport sink   (input valid, input cmd, input key, input value, output ready);
endinterface

interface kvt_out_if;
  logic                          valid;
  logic                          ready;
  logic [kvt_pkg::STATUS_W-1:0]  status;
  logic [kvt_pkg::VALUE_W-1:0]   found_value;
  logic [kvt_pkg::HELD_W-1:0]    entries_held;

  modport source (output valid, output status, output found_value, output entries_held,
                  input ready);
  modport sink   (input valid, input status, input found_value, input entries_held,
                  output ready);
endinterface

@@ rtl/kvt_cell.sv @@
// One table slot: stores a pair, compares against the query, passes hit info up the chain.
module kvt_cell #(
  parameter int INDEX       = 0,
  parameter int CW          = 5,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  kvt_pkg::kvt_cell_ctl_t ctl,
  input  logic [CW-1:0]          count,
  input  logic [KEY_WIDTH-1:0]   q_key,
  input  logic [VALUE_WIDTH-1:0] q_value,
  input  logic [KEY_WIDTH-1:0]   up_key,
  input  logic [VALUE_WIDTH-1:0] up_value,
  input  logic                   seen_in,
  input  logic [VALUE_WIDTH-1:0] hitval_in,
  output logic [KEY_WIDTH-1:0]   cell_key,
  output logic [VALUE_WIDTH-1:0] cell_value,
  output logic                   seen_out,
  output logic [VALUE_WIDTH-1:0] hitval_out
);

  logic occupied;
  logic hit;

  assign occupied   = CW'(INDEX) < count;
  assign seen_out   = seen_in | hit;
  assign hitval_out = hitval_in | (hit ? cell_value : '0);

  // Key compare is registered; the update acts on the registered hit.
  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else begin
      hit <= occupied && (cell_key == q_key);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.append && (CW'(INDEX) == count)) begin
      cell_key   <= q_key;
      cell_value <= q_value;
    end else if (ctl.shift && seen_out) begin
      cell_key   <= up_key;
      cell_value <= up_value;
    end
  end

endmodule

@@ rtl/key_value_table.sv @@
// Top level of the key-value table: controller, query registers and the cell chain.
//
//   channel | dir | fields                              | words
//   --------+-----+-------------------------------------+--------------------
//   req     | in  | cmd, key, value                     | one per operation
//   rsp     | out | status, found_value, entries_held   | one per request word
//
// Steps: a request is taken into the query registers, the cells register their key
// compare in the compare state, and the update plus response register load happen in
// the update state. The update state also takes the next request, so a new word is
// accepted while the previous one finishes.
// Reset: clears the entry count, the controller and response valid; the slot storage
// is not cleared, since only slots below the count are ever compared.
// Stalls: a held response word blocks the update cycle (and so the request side)
// until the sink takes it.
module key_value_table #(
  parameter int DEPTH       = 16,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  kvt_in_if.sink    req,
  kvt_out_if.source rsp
);

  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_UPD} state_t;

  state_t                 state;
  logic [CW-1:0]          count;
  logic [CW-1:0]          count_next;
  logic [1:0]             q_cmd;
  logic [KEY_WIDTH-1:0]   q_key;
  logic [VALUE_WIDTH-1:0] q_value;

  logic                   accept;
  logic                   can_finish;
  logic                   finish;
  logic                   any_hit;
  logic [VALUE_WIDTH-1:0] hit_value;
  kvt_pkg::kvt_status_t   status_next;
  logic [VALUE_WIDTH-1:0] found_next;
  logic                   do_append;
  logic                   do_shift;
  kvt_pkg::kvt_cell_ctl_t ctl;

  // Chain links: index i feeds cell i, index i+1 comes out of it.
  logic                   seen   [DEPTH+1];
  logic [VALUE_WIDTH-1:0] hitval [DEPTH+1];
  logic [KEY_WIDTH-1:0]   slot_key   [DEPTH];
  logic [VALUE_WIDTH-1:0] slot_value [DEPTH];

  assign can_finish = !rsp.valid || rsp.ready;
  assign finish     = (state == S_UPD) && can_finish;
  assign req.ready  = (state == S_IDLE) || finish;
  assign accept     = req.valid && req.ready;

  assign seen[0]   = 1'b0;
  assign hitval[0] = '0;
  assign any_hit   = seen[DEPTH];
  assign hit_value = hitval[DEPTH];

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic [KEY_WIDTH-1:0]   up_key;
      logic [VALUE_WIDTH-1:0] up_value;
      if (i == DEPTH - 1) begin : g_top
        // Top slot has no upper neighbor; what it takes on a shift is dropped anyway.
        assign up_key   = slot_key[i];
        assign up_value = slot_value[i];
      end else begin : g_mid
        assign up_key   = slot_key[i+1];
        assign up_value = slot_value[i+1];
      end
      kvt_cell #(
        .INDEX       (i),
        .CW          (CW),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctl        (ctl),
        .count      (count),
        .q_key      (q_key),
        .q_value    (q_value),
        .up_key     (up_key),
        .up_value   (up_value),
        .seen_in    (seen[i]),
        .hitval_in  (hitval[i]),
        .cell_key   (slot_key[i]),
        .cell_value (slot_value[i]),
        .seen_out   (seen[i+1]),
        .hitval_out (hitval[i+1])
      );
    end
  endgenerate

  // Operation decode, evaluated in the update cycle off the registered hits.
  always_comb begin
    status_next = kvt_pkg::ST_DONE;
    found_next  = '0;
    count_next  = count;
    do_append   = 1'b0;
    do_shift    = 1'b0;
    case (q_cmd)
      kvt_pkg::CMD_INSERT: begin
        if (any_hit) begin
          status_next = kvt_pkg::ST_DUP;   // duplicate wins over full
        end else if (count == CW'(DEPTH)) begin
          status_next = kvt_pkg::ST_FULL;
        end else begin
          do_append  = 1'b1;
          count_next = count + CW'(1);
        end
      end
      kvt_pkg::CMD_LOOKUP: begin
        if (any_hit) begin
          found_next = hit_value;
        end else begin
          status_next = kvt_pkg::ST_MISS;
        end
      end
      kvt_pkg::CMD_REMOVE: begin
        // Slots above the hole slide down one; slot order is not visible outside.
        if (any_hit) begin
          do_shift   = 1'b1;
          count_next = count - CW'(1);
        end else begin
          status_next = kvt_pkg::ST_MISS;
        end
      end
      default: begin
      end
    endcase
  end

  assign ctl.append = finish && do_append;
  assign ctl.shift  = finish && do_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      // a word taken in the same cycle as the next one loads stays valid
      if (rsp.valid && rsp.ready && !finish) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_UPD;
        end
        S_UPD: begin
          if (finish) begin
            count     <= count_next;
            rsp.valid <= 1'b1;
            state     <= accept ? S_CMP : S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Query and response payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      q_cmd   <= req.cmd;
      q_key   <= KEY_WIDTH'(req.key);
      q_value <= VALUE_WIDTH'(req.value);
    end
    if (finish) begin
      rsp.status       <= status_next;
      rsp.found_value  <= kvt_pkg::VALUE_W'(found_next);
      rsp.entries_held <= kvt_pkg::HELD_W'(count_next);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above capacity");

  a_rsp_from_upd: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == S_UPD))
    else $error("response raised outside update cycle");

  a_append_count: assert property (@(posedge clk) disable iff (rst)
    ctl.append |=> count == $past(count) + CW'(1))
    else $error("append did not grow count");

  a_shift_count: assert property (@(posedge clk) disable iff (rst)
    ctl.shift |=> count == $past(count) - CW'(1))
    else $error("remove did not shrink count");

  a_found_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status != kvt_pkg::ST_DONE) |-> rsp.found_value == '0)
    else $error("found value set on a failed operation");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for key_value_table: shadow table, random traffic, stalls.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS        = 16;
  localparam int RANDOM_WORDS = 600;
  localparam int KEY_POOL     = 32;
  localparam int MAX_WAIT     = 17;    // longest sender gap / receiver stall
  localparam int IDLE_LIMIT   = 2000;  // idle cycles before the watchdog trips
  localparam int DRAIN_CYCLES = 8;     // margin after the last owed reply, to catch strays

  // Code 3 has no enum member: the block must treat it as a no-op.
  localparam logic [kvt_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  // Traffic mixes for the random part.
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} traffic_mix_t;

  typedef struct {
    kvt_pkg::kvt_status_t          status;
    logic [kvt_pkg::VALUE_W-1:0]   found_value;
    logic [kvt_pkg::HELD_W-1:0]    entries_held;
  } reply_t;

  // Shadow copy of the table plus the replies it owes, oldest first.
  class table_shadow;
    logic [kvt_pkg::KEY_W-1:0]   keys   [SLOTS];
    logic [kvt_pkg::VALUE_W-1:0] values [SLOTS];
    int                          count;
    reply_t                      pending_replies [$];
    int                          mismatches;
    int                          requests;
    int                          peak;
    int                          drains;
    int                          seen [4];

    function new();
      count      = 0;
      mismatches = 0;
      requests   = 0;
      peak       = 0;
      drains     = 0;
      foreach (seen[i]) seen[i] = 0;
    endfunction

    function int slot_of(logic [kvt_pkg::KEY_W-1:0] key);
      for (int i = 0; i < count; i++)
        if (keys[i] == key) return i;
      return -1;
    endfunction

    // Accepted request word: update the shadow and queue the reply it causes.
    function void apply_request(logic [kvt_pkg::CMD_W-1:0] cmd,
                                logic [kvt_pkg::KEY_W-1:0] key,
                                logic [kvt_pkg::VALUE_W-1:0] value);
      reply_t r;
      int     slot;
      r.status      = kvt_pkg::ST_DONE;
      r.found_value = '0;
      slot          = slot_of(key);
      case (cmd)
        kvt_pkg::CMD_INSERT: begin
          // duplicate wins over full
          if (slot >= 0) r.status = kvt_pkg::ST_DUP;
          else if (count >= SLOTS) r.status = kvt_pkg::ST_FULL;
          else begin
            keys[count]   = key;
            values[count] = value;
            count++;
          end
        end
        kvt_pkg::CMD_LOOKUP: begin
          if (slot >= 0) r.found_value = values[slot];
          else r.status = kvt_pkg::ST_MISS;
        end
        kvt_pkg::CMD_REMOVE: begin
          // last entry fills the hole
          if (slot >= 0) begin
            keys[slot]   = keys[count-1];
            values[slot] = values[count-1];
            count--;
            if (count == 0) drains++;
          end else r.status = kvt_pkg::ST_MISS;
        end
        default: ;
      endcase
      r.entries_held = kvt_pkg::HELD_W'(count);
      if (count > peak) peak = count;
      requests++;
      pending_replies.push_back(r);
    endfunction

    // Accepted reply word: compare against the oldest owed reply.
    function void check_reply(logic [kvt_pkg::STATUS_W-1:0] status,
                              logic [kvt_pkg::VALUE_W-1:0] found_value,
                              logic [kvt_pkg::HELD_W-1:0] entries_held);
      reply_t want;
      if (pending_replies.size() == 0) begin
        $error("reply word with no request outstanding (status %0d)", status);
        mismatches++;
        return;
      end
      want = pending_replies.pop_front();
      seen[want.status]++;
      if (status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status);
        mismatches++;
      end
      if (found_value !== want.found_value) begin
        $error("found_value: expected %h, got %h", want.found_value, found_value);
        mismatches++;
      end
      if (entries_held !== want.entries_held) begin
        $error("entries_held: expected %0d, got %0d", want.entries_held, entries_held);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic sender_calm;    // when set, the sender runs with no gaps
  logic receiver_calm;  // when set, the receiver never stalls
  int   idle_cycles = 0;

  logic [kvt_pkg::KEY_W-1:0] key_pool [KEY_POOL];

  table_shadow shadow = new();

  kvt_in_if  req ();
  kvt_out_if rsp ();

  key_value_table #(
    .DEPTH       (SLOTS),
    .KEY_WIDTH   (kvt_pkg::KEY_W),
    .VALUE_WIDTH (kvt_pkg::VALUE_W)
  ) dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Monitors: sample at the edge, before the block's own updates land.
  always @(posedge clk) begin
    if (!rst && req.valid && req.ready)
      shadow.apply_request(req.cmd, req.key, req.value);
    if (!rst && rsp.valid && rsp.ready)
      shadow.check_reply(rsp.status, rsp.found_value, rsp.entries_held);
    // watchdog count: any accepted word on either side clears it
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  // Watchdog: too long with no word moving means the block hung.
  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Offer one request word after a random gap; return at the edge it is taken.
  // Gap zero keeps valid high, so valid never gets two updates in one step.
  task automatic send_word(input logic [kvt_pkg::CMD_W-1:0] cmd,
                           input logic [kvt_pkg::KEY_W-1:0] key,
                           input logic [kvt_pkg::VALUE_W-1:0] value);
    int gap;
    if ($urandom_range(0, 24) == 0) sender_calm = !sender_calm;
    gap = sender_calm ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.cmd   <= cmd;
    req.key   <= key;
    req.value <= value;
    do @(posedge clk); while (req.ready !== 1'b1);
  endtask

  // Receiver: random stall before each reply word, with calm stretches.
  initial begin
    int stall;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 24) == 0) receiver_calm = !receiver_calm;
      stall = receiver_calm ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (rsp.valid !== 1'b1 || rst);
    end
  end

  initial begin
    traffic_mix_t              mix;
    int                        roll;
    logic [kvt_pkg::CMD_W-1:0] cmd;
    logic [kvt_pkg::KEY_W-1:0] key;

    // known values on every input before the first edge
    rst           <= 1'b1;
    req.valid     <= 1'b0;
    req.cmd       <= kvt_pkg::CMD_INSERT;
    req.key       <= '0;
    req.value     <= '0;
    rsp.ready     <= 1'b0;
    sender_calm   = 1'b0;
    receiver_calm = 1'b0;
    mix           = MIX_EVEN;

    // pool of keys that recur, so lookups and removes hit; extremes included
    foreach (key_pool[i]) key_pool[i] = $urandom();
    key_pool[0] = '0;
    key_pool[1] = '1;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // --- directed part ---
    send_word(kvt_pkg::CMD_INSERT, '0, '1);            // smallest key, largest value
    send_word(kvt_pkg::CMD_INSERT, '1, '0);            // largest key, smallest value
    send_word(kvt_pkg::CMD_INSERT, '0, 32'h1234_5678); // duplicate: ignored
    send_word(kvt_pkg::CMD_LOOKUP, '0, '0);
    send_word(kvt_pkg::CMD_LOOKUP, '1, '1);
    send_word(kvt_pkg::CMD_LOOKUP, 32'h5555_AAAA, '0); // lookup miss
    send_word(kvt_pkg::CMD_REMOVE, 32'hAAAA_5555, '0); // remove miss
    send_word(CMD_UNUSED, '0, '1);                     // unused code: no-op
    // fill the remaining slots
    for (int i = 2; i < SLOTS; i++)
      send_word(kvt_pkg::CMD_INSERT, 32'h0F0F_0000 + i, 32'hC0DE_0000 + i);
    send_word(kvt_pkg::CMD_INSERT, 32'h7777_7777, '1); // table full
    send_word(kvt_pkg::CMD_INSERT, '1, '1);            // duplicate beats full
    send_word(kvt_pkg::CMD_REMOVE, '0, '0);            // hole at slot 0, last moves in
    send_word(kvt_pkg::CMD_LOOKUP, 32'h0F0F_0000 + SLOTS - 1, '0);
    send_word(CMD_UNUSED, '1, '1);

    // --- random part: mixes that swing the table between full and empty ---
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 40 == 0) mix = traffic_mix_t'($urandom_range(0, 2));
      roll = $urandom_range(0, 99);
      case (mix)
        MIX_FILL:
          cmd = (roll < 60) ? kvt_pkg::CMD_INSERT : (roll < 80) ? kvt_pkg::CMD_LOOKUP :
                (roll < 97) ? kvt_pkg::CMD_REMOVE : CMD_UNUSED;
        MIX_DRAIN:
          cmd = (roll < 15) ? kvt_pkg::CMD_INSERT : (roll < 40) ? kvt_pkg::CMD_LOOKUP :
                (roll < 97) ? kvt_pkg::CMD_REMOVE : CMD_UNUSED;
        default:
          cmd = (roll < 35) ? kvt_pkg::CMD_INSERT : (roll < 65) ? kvt_pkg::CMD_LOOKUP :
                (roll < 95) ? kvt_pkg::CMD_REMOVE : CMD_UNUSED;
      endcase
      // mostly pool keys; fresh random ones give misses and toggle every bit
      key = ($urandom_range(0, 99) < 80) ? key_pool[$urandom_range(0, KEY_POOL - 1)]
                                         : $urandom();
      send_word(cmd, key, $urandom());
    end
    req.valid <= 1'b0;

    // let every owed reply arrive, then watch for strays
    while (shadow.pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d request words: %0d done, %0d duplicate, %0d not found, %0d full",
             shadow.requests, shadow.seen[kvt_pkg::ST_DONE], shadow.seen[kvt_pkg::ST_DUP],
             shadow.seen[kvt_pkg::ST_MISS], shadow.seen[kvt_pkg::ST_FULL]);
    $display("table peaked at %0d of %0d entries, emptied by removes %0d times",
             shadow.peak, SLOTS, shadow.drains);
    if (shadow.mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
